// ===== design/lswc_pkg.sv =====
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared types, constants and control store for the line segment window
// clipper: coordinate formats, region codes, control word layout and the
// microprogram that sequences one clip.
// ----------------------------------------------------------------------------
package lswc_pkg;

	// Coordinate and fixed-point formats
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int CW         = COORD_BITS + FRAC_BITS;	// Q16 coordinate width
	localparam int MAX_STEPS  = 8;
	localparam int STEP_W     = $clog2(MAX_STEPS + 1);
	localparam int PC_W       = 4;
	localparam int CFG_IDX_W  = 2;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CW-1:0]         fix_t;
	typedef logic [3:0]            code_t;
	typedef logic [PC_W-1:0]       pc_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	// Region code bits (screen y grows downward)
	localparam code_t CODE_LEFT   = 4'b0001;
	localparam code_t CODE_TOP    = 4'b0010;
	localparam code_t CODE_RIGHT  = 4'b0100;
	localparam code_t CODE_BOTTOM = 4'b1000;

	// Configuration register indices and reset values
	localparam cfg_idx_t REG_LEFT   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_RIGHT  = cfg_idx_t'(1);
	localparam cfg_idx_t REG_TOP    = cfg_idx_t'(2);
	localparam cfg_idx_t REG_BOTTOM = cfg_idx_t'(3);
	localparam coord_t   EDGE_LO_RST = coord_t'(0);
	localparam coord_t   EDGE_HI_RST = coord_t'(4095);

	// Window held in configuration
	typedef struct packed {
		coord_t left;
		coord_t right;
		coord_t top;
		coord_t bottom;
	} win_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_CODES,
		OP_SETUP,
		OP_SAT,
		OP_MUL,
		OP_DIVGO,
		OP_UPDATE,
		OP_EMIT_ACC,
		OP_EMIT_REJ
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_IN,
		COND_ACC,
		COND_REJ,
		COND_ZDIV,
		COND_DIV_BUSY,
		COND_OUT_BUSY
	} cond_t;

	// One control word
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic acc;
		logic rej;
		logic zdiv;
		logic div_busy;
	} dp_sts_t;

	// Microprogram addresses
	localparam pc_t PC_WAIT     = pc_t'(0);
	localparam pc_t PC_CODES    = pc_t'(1);
	localparam pc_t PC_TST_ACC  = pc_t'(2);
	localparam pc_t PC_TST_REJ  = pc_t'(3);
	localparam pc_t PC_SETUP    = pc_t'(4);
	localparam pc_t PC_SAT      = pc_t'(5);
	localparam pc_t PC_MUL      = pc_t'(6);
	localparam pc_t PC_DIVGO    = pc_t'(7);
	localparam pc_t PC_DIVWAIT  = pc_t'(8);
	localparam pc_t PC_UPDATE   = pc_t'(9);
	localparam pc_t PC_EMIT_ACC = pc_t'(10);
	localparam pc_t PC_ACC_RET  = pc_t'(11);
	localparam pc_t PC_EMIT_REJ = pc_t'(12);
	localparam pc_t PC_REJ_RET  = pc_t'(13);

	// Control store: a jump is taken when its condition holds, else pc + 1
	function automatic ctrl_t ucode_rom(input pc_t pc);
		ctrl_t w;
		w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_WAIT};
		case (pc)
			PC_WAIT:     w = '{op: OP_LOAD,     cond: COND_NO_IN,    target: PC_WAIT};
			PC_CODES:    w = '{op: OP_CODES,    cond: COND_NEVER,    target: PC_WAIT};
			PC_TST_ACC:  w = '{op: OP_NOP,      cond: COND_ACC,      target: PC_EMIT_ACC};
			PC_TST_REJ:  w = '{op: OP_NOP,      cond: COND_REJ,      target: PC_EMIT_REJ};
			PC_SETUP:    w = '{op: OP_SETUP,    cond: COND_NEVER,    target: PC_WAIT};
			PC_SAT:      w = '{op: OP_SAT,      cond: COND_ZDIV,     target: PC_EMIT_REJ};
			PC_MUL:      w = '{op: OP_MUL,      cond: COND_NEVER,    target: PC_WAIT};
			PC_DIVGO:    w = '{op: OP_DIVGO,    cond: COND_NEVER,    target: PC_WAIT};
			PC_DIVWAIT:  w = '{op: OP_NOP,      cond: COND_DIV_BUSY, target: PC_DIVWAIT};
			PC_UPDATE:   w = '{op: OP_UPDATE,   cond: COND_ALWAYS,   target: PC_CODES};
			PC_EMIT_ACC: w = '{op: OP_EMIT_ACC, cond: COND_OUT_BUSY, target: PC_EMIT_ACC};
			PC_ACC_RET:  w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_WAIT};
			PC_EMIT_REJ: w = '{op: OP_EMIT_REJ, cond: COND_OUT_BUSY, target: PC_EMIT_REJ};
			PC_REJ_RET:  w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_WAIT};
			default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== design/lswc_div.sv =====
// ----------------------------------------------------------------------------
// lswc_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in CW bits (upper half of the dividend below the divisor).
// ----------------------------------------------------------------------------
module lswc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [2*lswc_pkg::CW-1:0]       dividend,
	input  lswc_pkg::fix_t                  divisor,
	output logic                            busy,
	output lswc_pkg::fix_t                  quotient
);

	localparam int CW    = lswc_pkg::CW;
	localparam int CNT_W = $clog2(CW + 1);

	logic [CNT_W-1:0] cnt_q;
	lswc_pkg::fix_t   rem_q;
	lswc_pkg::fix_t   lo_q;	// dividend bits still to come; quotient shifts in
	lswc_pkg::fix_t   dvs_q;
	logic [CW:0]      trial;
	logic [CW+1:0]    diff;
	logic             ge;

	// Trial subtract
	always_comb begin
		trial = {rem_q, lo_q[CW-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		ge    = ~diff[CW+1];
	end

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(CW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*CW-1:CW];
			lo_q  <= dividend[CW-1:0];
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			lo_q  <= {lo_q[CW-2:0], ge};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = lo_q;

endmodule

// ===== design/lswc_dp.sv =====
// ----------------------------------------------------------------------------
// lswc_dp
// Clipping datapath: endpoint registers, region codes, crossing setup,
// multiplier and divider, endpoint update and pixel rounding.
// ----------------------------------------------------------------------------
module lswc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  lswc_pkg::op_t     op,
	input  logic              load,
	input  lswc_pkg::win_t    win,
	input  lswc_pkg::coord_t  start_x,
	input  lswc_pkg::coord_t  start_y,
	input  lswc_pkg::coord_t  end_x,
	input  lswc_pkg::coord_t  end_y,
	output lswc_pkg::dp_sts_t sts,
	output lswc_pkg::coord_t  pix_x1,
	output lswc_pkg::coord_t  pix_y1,
	output lswc_pkg::coord_t  pix_x2,
	output lswc_pkg::coord_t  pix_y2
);

	localparam int CW = lswc_pkg::CW;
	localparam int FB = lswc_pkg::FRAC_BITS;

	// Endpoints and codes
	lswc_pkg::fix_t  x1_q, y1_q, x2_q, y2_q;
	lswc_pkg::code_t c1_q, c2_q;
	logic [lswc_pkg::STEP_W-1:0] steps_q;

	// Crossing operands
	lswc_pkg::fix_t  e_q, base_q, ua_q, ub_q, ud_q;
	logic            neg_q, vert_q, first_q;
	logic [2*CW-1:0] prod_q;

	// Window in Q16
	lswc_pkg::fix_t l_f, r_f, t_f, b_f;

	// Setup wires
	lswc_pkg::code_t c_sel;
	logic            first_c, vert_c;
	lswc_pkg::fix_t  e_c, p1, p2, q1, q2;
	logic [CW:0]     a_c, b_c, d_c;

	// Update wires
	logic            div_busy;
	lswc_pkg::fix_t  quot;
	logic [CW:0]     sum_c;
	lswc_pkg::fix_t  new_c;
	logic            empty;

	function automatic lswc_pkg::code_t region(input lswc_pkg::fix_t x,
			input lswc_pkg::fix_t y, input lswc_pkg::fix_t l, input lswc_pkg::fix_t t,
			input lswc_pkg::fix_t r, input lswc_pkg::fix_t b);
		lswc_pkg::code_t c;
		c = '0;
		if (x < l)      c = c | lswc_pkg::CODE_LEFT;
		else if (x > r) c = c | lswc_pkg::CODE_RIGHT;
		if (y < t)      c = c | lswc_pkg::CODE_TOP;
		else if (y > b) c = c | lswc_pkg::CODE_BOTTOM;
		return c;
	endfunction

	function automatic lswc_pkg::fix_t mag(input logic [CW:0] v);
		logic [CW:0] n;
		n = -v;
		return v[CW] ? n[CW-1:0] : v[CW-1:0];
	endfunction

	// Round Q16 to the nearest pixel, halves upward
	function automatic lswc_pkg::coord_t pixel(input lswc_pkg::fix_t v);
		logic [CW:0] s;
		s = {1'b0, v} + (CW+1)'(1 << (FB - 1));
		return s[CW-1:FB];
	endfunction

	assign l_f = {win.left,   {FB{1'b0}}};
	assign r_f = {win.right,  {FB{1'b0}}};
	assign t_f = {win.top,    {FB{1'b0}}};
	assign b_f = {win.bottom, {FB{1'b0}}};

	// Outside endpoint and first crossed edge
	always_comb begin
		first_c = (c1_q != '0);
		c_sel   = first_c ? c1_q : c2_q;
		if ((c_sel & lswc_pkg::CODE_LEFT) != '0) begin
			e_c = l_f; vert_c = 1'b1;
		end else if ((c_sel & lswc_pkg::CODE_TOP) != '0) begin
			e_c = t_f; vert_c = 1'b0;
		end else if ((c_sel & lswc_pkg::CODE_RIGHT) != '0) begin
			e_c = r_f; vert_c = 1'b1;
		end else begin
			e_c = b_f; vert_c = 1'b0;
		end
		p1  = vert_c ? x1_q : y1_q;
		p2  = vert_c ? x2_q : y2_q;
		q1  = vert_c ? y1_q : x1_q;
		q2  = vert_c ? y2_q : x2_q;
		a_c = {1'b0, e_c} - {1'b0, p1};
		b_c = {1'b0, p2}  - {1'b0, p1};
		d_c = {1'b0, q2}  - {1'b0, q1};
	end

	// New coordinate along the crossed edge
	always_comb begin
		sum_c = neg_q ? ({1'b0, base_q} - {1'b0, quot}) : ({1'b0, base_q} + {1'b0, quot});
		new_c = sum_c[CW-1:0];
	end

	// Operation registers
	always_ff @(posedge clk) begin
		case (op)
			lswc_pkg::OP_LOAD: begin
				if (load) begin
					x1_q    <= {start_x, {FB{1'b0}}};
					y1_q    <= {start_y, {FB{1'b0}}};
					x2_q    <= {end_x,   {FB{1'b0}}};
					y2_q    <= {end_y,   {FB{1'b0}}};
					steps_q <= '0;
				end
			end
			lswc_pkg::OP_CODES: begin
				c1_q <= region(x1_q, y1_q, l_f, t_f, r_f, b_f);
				c2_q <= region(x2_q, y2_q, l_f, t_f, r_f, b_f);
			end
			lswc_pkg::OP_SETUP: begin
				e_q     <= e_c;
				vert_q  <= vert_c;
				first_q <= first_c;
				base_q  <= q1;
				ua_q    <= mag(a_c);
				ub_q    <= mag(b_c);
				ud_q    <= mag(d_c);
				neg_q   <= a_c[CW] ^ b_c[CW] ^ d_c[CW];
			end
			lswc_pkg::OP_SAT: begin
				// ratio capped at one keeps the point between the endpoints
				if (ua_q > ub_q) ua_q <= ub_q;
			end
			lswc_pkg::OP_MUL: begin
				prod_q <= ua_q * ud_q;
			end
			lswc_pkg::OP_UPDATE: begin
				steps_q <= steps_q + 1'b1;
				if (first_q) begin
					x1_q <= vert_q ? e_q : new_c;
					y1_q <= vert_q ? new_c : e_q;
				end else begin
					x2_q <= vert_q ? e_q : new_c;
					y2_q <= vert_q ? new_c : e_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Divider: round-to-nearest by adding half the divisor
	lswc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op == lswc_pkg::OP_DIVGO),
		.dividend (prod_q + {{(CW+1){1'b0}}, ub_q[CW-1:1]}),
		.divisor  (ub_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	// Status
	always_comb begin
		empty        = (win.left > win.right) || (win.top > win.bottom);
		sts.acc      = !empty && ((c1_q | c2_q) == '0);
		sts.rej      = empty || ((c1_q & c2_q) != '0) ||
			(steps_q == lswc_pkg::STEP_W'(lswc_pkg::MAX_STEPS));
		sts.zdiv     = (ub_q == '0);
		sts.div_busy = div_busy;
	end

	assign pix_x1 = pixel(x1_q);
	assign pix_y1 = pixel(y1_q);
	assign pix_x2 = pixel(x2_q);
	assign pix_y2 = pixel(y2_q);

endmodule

// ===== design/lswc_seq.sv =====
// ----------------------------------------------------------------------------
// lswc_seq
// Microsequencer: step counter, control store lookup and conditional jump.
// ----------------------------------------------------------------------------
module lswc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_busy,
	input  lswc_pkg::dp_sts_t sts,
	output lswc_pkg::ctrl_t   ctrl
);

	lswc_pkg::pc_t pc_q;
	logic          taken;

	assign ctrl = lswc_pkg::ucode_rom(pc_q);

	// Jump condition
	always_comb begin
		case (ctrl.cond)
			lswc_pkg::COND_NEVER:    taken = 1'b0;
			lswc_pkg::COND_ALWAYS:   taken = 1'b1;
			lswc_pkg::COND_NO_IN:    taken = !in_valid;
			lswc_pkg::COND_ACC:      taken = sts.acc;
			lswc_pkg::COND_REJ:      taken = sts.rej;
			lswc_pkg::COND_ZDIV:     taken = sts.zdiv;
			lswc_pkg::COND_DIV_BUSY: taken = sts.div_busy;
			lswc_pkg::COND_OUT_BUSY: taken = out_busy;
			default:                 taken = 1'b1;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lswc_pkg::PC_WAIT;
		end else begin
			pc_q <= taken ? ctrl.target : pc_q + 1'b1;
		end
	end

endmodule

// ===== design/line_segment_window_clipper_core.sv =====
// ----------------------------------------------------------------------------
// line_segment_window_clipper_core
// Cohen-Sutherland segment clipper against a window held in four registers.
// ----------------------------------------------------------------------------
// One segment is taken at a time. After the input transfer the block forms
// the region codes and tests for a trivial accept or reject; for every
// endpoint it moves onto an edge, at most eight moves, it sets up the
// crossing, caps the ratio, multiplies, runs the bit-serial divider (one
// quotient bit per cycle over a Q16 coordinate) and updates the endpoint.
// The result sits in an output register, so a new segment is accepted while
// the previous result still waits for its transfer. Configuration writes are
// taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
module line_segment_window_clipper_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  lswc_pkg::cfg_idx_t          cfg_index,
	input  lswc_pkg::coord_t            cfg_data,
	// segment in
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lswc_pkg::coord_t            start_x,
	input  lswc_pkg::coord_t            start_y,
	input  lswc_pkg::coord_t            end_x,
	input  lswc_pkg::coord_t            end_y,
	// result out
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output lswc_pkg::coord_t            clip_start_x,
	output lswc_pkg::coord_t            clip_start_y,
	output lswc_pkg::coord_t            clip_end_x,
	output lswc_pkg::coord_t            clip_end_y
);

	lswc_pkg::win_t    win_q;
	lswc_pkg::ctrl_t   ctrl;
	lswc_pkg::dp_sts_t sts;
	lswc_pkg::coord_t  pix_x1, pix_y1, pix_x2, pix_y2;
	logic              out_valid_q;
	logic              out_busy;
	logic              emit;
	logic              emit_acc;

	// Window registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.left   <= lswc_pkg::EDGE_LO_RST;
			win_q.right  <= lswc_pkg::EDGE_HI_RST;
			win_q.top    <= lswc_pkg::EDGE_LO_RST;
			win_q.bottom <= lswc_pkg::EDGE_HI_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lswc_pkg::REG_LEFT:   win_q.left   <= cfg_data;
				lswc_pkg::REG_RIGHT:  win_q.right  <= cfg_data;
				lswc_pkg::REG_TOP:    win_q.top    <= cfg_data;
				lswc_pkg::REG_BOTTOM: win_q.bottom <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and datapath
	assign in_ready = (ctrl.op == lswc_pkg::OP_LOAD);
	assign out_busy = out_valid_q && !out_ready;

	lswc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	lswc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (ctrl.op),
		.load    (in_valid && in_ready),
		.win     (win_q),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.sts     (sts),
		.pix_x1  (pix_x1),
		.pix_y1  (pix_y1),
		.pix_x2  (pix_x2),
		.pix_y2  (pix_y2)
	);

	// Output register
	assign emit_acc = (ctrl.op == lswc_pkg::OP_EMIT_ACC);
	assign emit     = (emit_acc || (ctrl.op == lswc_pkg::OP_EMIT_REJ)) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			accepted     <= emit_acc;
			clip_start_x <= emit_acc ? pix_x1 : '0;
			clip_start_y <= emit_acc ? pix_y1 : '0;
			clip_end_x   <= emit_acc ? pix_x2 : '0;
			clip_end_y   <= emit_acc ? pix_y2 : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== bench/line_segment_window_clipper_core_tb.sv =====
// ----------------------------------------------------------------------------
// line_segment_window_clipper_core_tb
// Self-checking bench for the Cohen-Sutherland segment clipper. Segments are
// queued by the stimulus sequence, driven by a clocked driver and collected by
// a clocked monitor. Each segment taken by the block is clipped by a local
// Q16 fixed-point predictor against the window last written, and every result
// transfer is compared field by field with the oldest prediction. Windows run
// through full, empty, degenerate and random settings, and both handshakes
// stall at random. The receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
module line_segment_window_clipper_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_MAX   = (1 << lswc_pkg::COORD_BITS) - 1;
	localparam int QUIET_LIMIT = 5000;	// cycles with no transfer at all
	localparam int LONG_HOLD   = 400;	// receiver hold-off, in cycles

	typedef struct packed {
		lswc_pkg::coord_t sx;
		lswc_pkg::coord_t sy;
		lswc_pkg::coord_t ex;
		lswc_pkg::coord_t ey;
	} segment_t;

	typedef struct packed {
		logic             accepted;
		lswc_pkg::coord_t sx;
		lswc_pkg::coord_t sy;
		lswc_pkg::coord_t ex;
		lswc_pkg::coord_t ey;
	} clip_result_t;

	// clock, reset and block ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	lswc_pkg::cfg_idx_t cfg_index = lswc_pkg::REG_LEFT;
	lswc_pkg::coord_t   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	lswc_pkg::coord_t   start_x = '0;
	lswc_pkg::coord_t   start_y = '0;
	lswc_pkg::coord_t   end_x = '0;
	lswc_pkg::coord_t   end_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               accepted;
	lswc_pkg::coord_t   clip_start_x;
	lswc_pkg::coord_t   clip_start_y;
	lswc_pkg::coord_t   clip_end_x;
	lswc_pkg::coord_t   clip_end_y;

	// bench state
	segment_t       seg_backlog[$];	// segments waiting to be offered
	clip_result_t   clip_due[$];	// predicted results, oldest first
	segment_t       cur_seg;
	lswc_pkg::win_t window_now = '{left: lswc_pkg::EDGE_LO_RST, right: lswc_pkg::EDGE_HI_RST,
	                               top: lswc_pkg::EDGE_LO_RST, bottom: lswc_pkg::EDGE_HI_RST};
	bit             gaps_on = 1'b1;
	int             send_gap = 0;
	int             stall_cnt = 0;
	int             hold_cnt = 0;
	int             results_seen = 0;
	int             errors = 0;
	int             quiet_cycles = 0;

	line_segment_window_clipper_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.clip_start_x (clip_start_x),
		.clip_start_y (clip_start_y),
		.clip_end_x   (clip_end_x),
		.clip_end_y   (clip_end_y)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Region code of a Q16 point; y grows downward
	function automatic lswc_pkg::code_t outcode(longint x, longint y, longint l, longint t,
	                                            longint r, longint b);
		lswc_pkg::code_t c;
		c = '0;
		if (x < l) c |= lswc_pkg::CODE_LEFT;
		else if (x > r) c |= lswc_pkg::CODE_RIGHT;
		if (y < t) c |= lswc_pkg::CODE_TOP;
		else if (y > b) c |= lswc_pkg::CODE_BOTTOM;
		return c;
	endfunction

	// Coordinate q where the line (p1,q1)-(p2,q2) meets p = e. The ratio is
	// clamped to one and the quotient rounds half away from zero.
	function automatic longint edge_cross(longint p1, longint q1, longint p2,
	                                      longint q2, longint e, output bit ok);
		longint a, b, d;
		longint unsigned ua, ub, ud, q;
		bit neg;
		a = e - p1;
		b = p2 - p1;
		d = q2 - q1;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		ud = (d < 0) ? -d : d;
		neg = ((a < 0) != (b < 0)) != (d < 0);
		ok = 1'b1;
		if (ub == 0) begin
			ok = 1'b0;
			return q1;
		end
		if (ua > ub) ua = ub;
		q = (ua * ud + ub / 2) / ub;
		return neg ? q1 - longint'(q) : q1 + longint'(q);
	endfunction

	// Q16 to whole pixel, half rounds up
	function automatic lswc_pkg::coord_t pixel_of(longint v);
		longint unsigned u;
		u = ($unsigned(v) + (64'd1 << (lswc_pkg::FRAC_BITS - 1))) >> lswc_pkg::FRAC_BITS;
		return lswc_pkg::coord_t'(u);
	endfunction

	function automatic clip_result_t clip_segment(segment_t s, lswc_pkg::win_t w);
		clip_result_t res;
		longint l, r, t, b, x1, y1, x2, y2, xi, yi;
		lswc_pkg::code_t c1, c2, c;
		bit ok, done, take, first;
		int n;
		res = '0;
		l = longint'(w.left) << lswc_pkg::FRAC_BITS;
		r = longint'(w.right) << lswc_pkg::FRAC_BITS;
		t = longint'(w.top) << lswc_pkg::FRAC_BITS;
		b = longint'(w.bottom) << lswc_pkg::FRAC_BITS;
		x1 = longint'(s.sx) << lswc_pkg::FRAC_BITS;
		y1 = longint'(s.sy) << lswc_pkg::FRAC_BITS;
		x2 = longint'(s.ex) << lswc_pkg::FRAC_BITS;
		y2 = longint'(s.ey) << lswc_pkg::FRAC_BITS;
		// an empty window holds no point at all
		if (l > r || t > b) return res;
		c1 = outcode(x1, y1, l, t, r, b);
		c2 = outcode(x2, y2, l, t, r, b);
		take = 1'b0;
		done = 1'b0;
		for (n = 0; n <= lswc_pkg::MAX_STEPS && !done; n++) begin
			if ((c1 | c2) == 0) begin
				take = 1'b1;
				done = 1'b1;
			end else if ((c1 & c2) != 0 || n == lswc_pkg::MAX_STEPS) begin
				done = 1'b1;
			end else begin
				// start point moves first; edges in left, top, right, bottom order
				first = (c1 != 0);
				c = first ? c1 : c2;
				if ((c & lswc_pkg::CODE_LEFT) != 0) begin
					xi = l;
					yi = edge_cross(x1, y1, x2, y2, l, ok);
				end else if ((c & lswc_pkg::CODE_TOP) != 0) begin
					yi = t;
					xi = edge_cross(y1, x1, y2, x2, t, ok);
				end else if ((c & lswc_pkg::CODE_RIGHT) != 0) begin
					xi = r;
					yi = edge_cross(x1, y1, x2, y2, r, ok);
				end else begin
					yi = b;
					xi = edge_cross(y1, x1, y2, x2, b, ok);
				end
				if (!ok) begin
					done = 1'b1;
				end else if (first) begin
					x1 = xi;
					y1 = yi;
					c1 = outcode(x1, y1, l, t, r, b);
				end else begin
					x2 = xi;
					y2 = yi;
					c2 = outcode(x2, y2, l, t, r, b);
				end
			end
		end
		if (take) begin
			res.accepted = 1'b1;
			res.sx = pixel_of(x1);
			res.sy = pixel_of(y1);
			res.ex = pixel_of(x2);
			res.ey = pixel_of(y2);
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Idle length: mostly short, now and then long
	function automatic int pick_gap();
		if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Coordinate biased towards the window span and its edges
	function automatic lswc_pkg::coord_t pick_coord(lswc_pkg::coord_t lo, lswc_pkg::coord_t hi);
		int sel, off, v;
		sel = $urandom_range(0, 9);
		off = $urandom_range(0, 6);
		if (sel < 4) v = $urandom_range(0, COORD_MAX);
		else if (sel < 6) v = int'(lo) + off - 3;
		else if (sel < 7) v = int'(hi) + off - 3;
		else if (sel < 9) v = $urandom_range(int'(lo), int'(hi));
		else v = $urandom_range(0, 1) ? COORD_MAX : 0;
		if (v < 0) v = 0;
		if (v > COORD_MAX) v = COORD_MAX;
		return lswc_pkg::coord_t'(v);
	endfunction

	task automatic push_seg(int sx, int sy, int ex, int ey);
		segment_t s;
		s.sx = lswc_pkg::coord_t'(sx);
		s.sy = lswc_pkg::coord_t'(sy);
		s.ex = lswc_pkg::coord_t'(ex);
		s.ey = lswc_pkg::coord_t'(ey);
		seg_backlog.insert(seg_backlog.size(), s);
	endtask

	task automatic write_edge(lswc_pkg::cfg_idx_t idx, lswc_pkg::coord_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			lswc_pkg::REG_LEFT:   window_now.left   = val;
			lswc_pkg::REG_RIGHT:  window_now.right  = val;
			lswc_pkg::REG_TOP:    window_now.top    = val;
			lswc_pkg::REG_BOTTOM: window_now.bottom = val;
			default: ;
		endcase
	endtask

	task automatic set_window(int l, int r, int t, int b);
		write_edge(lswc_pkg::REG_LEFT, lswc_pkg::coord_t'(l));
		write_edge(lswc_pkg::REG_RIGHT, lswc_pkg::coord_t'(r));
		write_edge(lswc_pkg::REG_TOP, lswc_pkg::coord_t'(t));
		write_edge(lswc_pkg::REG_BOTTOM, lswc_pkg::coord_t'(b));
	endtask

	// Wait until every queued segment is taken and every result is back
	task automatic wait_idle();
		do @(posedge clk);
		while (seg_backlog.size() != 0 || in_valid || clip_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch at result %0d: %s got %0d expected %0d",
		         results_seen, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Segment driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_seg
		logic nv;
		nv = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				clip_due.insert(clip_due.size(), clip_segment(cur_seg, window_now));
				nv = 1'b0;
				if (gaps_on && $urandom_range(0, 2) == 0) send_gap = pick_gap();
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (seg_backlog.size() != 0) begin
					cur_seg = seg_backlog.pop_front();
					nv = 1'b1;
					start_x <= cur_seg.sx;
					start_y <= cur_seg.sy;
					end_x   <= cur_seg.ex;
					end_y   <= cur_seg.ey;
				end
			end
		end
		in_valid <= nv;
	end

	// ------------------------------------------------------------------
	// Result monitor and receiver back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_result
		clip_result_t want;
		logic nr;
		nr = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (clip_due.size() == 0) begin
					report_mismatch("result with none pending", accepted, 0);
				end else begin
					want = clip_due.pop_front();
					if (accepted !== want.accepted)
						report_mismatch("accepted", accepted, want.accepted);
					if (clip_start_x !== want.sx)
						report_mismatch("clip_start_x", clip_start_x, want.sx);
					if (clip_start_y !== want.sy)
						report_mismatch("clip_start_y", clip_start_y, want.sy);
					if (clip_end_x !== want.ex)
						report_mismatch("clip_end_x", clip_end_x, want.ex);
					if (clip_end_y !== want.ey)
						report_mismatch("clip_end_y", clip_end_y, want.ey);
				end
				// long hold-offs so the block backs up onto its input
				if (results_seen == 150 || results_seen == 800) hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall_cnt = pick_gap() - 1;
			end else begin
				nr = 1'b1;
			end
		end
		out_ready <= nr;
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : test_seq
		int ph, kind, n, i, a0, a1, l, r, t, b;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window covers the whole coordinate space
		push_seg(0, 0, COORD_MAX, COORD_MAX);
		push_seg(COORD_MAX, 0, 0, COORD_MAX);
		push_seg(2048, 1, 1, 2048);
		wait_idle();

		// directed cases against a centred window
		set_window(1000, 3000, 800, 2500);
		push_seg(1500, 1000, 2500, 2000);	// fully inside
		push_seg(0, 0, COORD_MAX, COORD_MAX);	// both ends clipped
		push_seg(COORD_MAX, COORD_MAX, 0, 0);
		push_seg(100, 1000, 900, 2000);	// all left
		push_seg(1500, 100, 2500, 700);	// all above
		push_seg(3100, 1000, COORD_MAX, 2000);	// all right
		push_seg(1500, 2600, 2500, COORD_MAX);	// all below
		push_seg(500, 1500, 2000, 1500);	// horizontal over left edge
		push_seg(2000, 1500, 3500, 1500);	// end over right edge
		push_seg(2000, 0, 2000, COORD_MAX);	// vertical over top and bottom
		push_seg(2000, 2000, 2000, 2000);	// point inside
		push_seg(0, 0, 0, 0);	// point outside
		push_seg(1000, 800, 3000, 2500);	// ends on corners
		push_seg(0, 1500, 1500, 0);	// passes by the corner, rejected late
		push_seg(COORD_MAX, 0, 0, COORD_MAX);
		push_seg(2999, 2501, 3001, 2499);	// grazes bottom-right corner
		push_seg(1001, 799, 999, 801);	// grazes top-left corner
		push_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		push_seg(1234, 2100, 3456, 650);
		wait_idle();

		// empty windows, horizontally and vertically
		set_window(3000, 1000, 800, 2500);
		push_seg(2000, 1500, 2000, 1500);
		push_seg(0, 0, COORD_MAX, COORD_MAX);
		wait_idle();
		set_window(1000, 3000, 2500, 800);
		push_seg(2000, 1500, 2000, 1500);
		push_seg(0, 0, COORD_MAX, COORD_MAX);
		wait_idle();

		// random phases, each with its own window
		for (ph = 0; ph < 10; ph++) begin
			kind = (ph < 4) ? ph : $urandom_range(0, 9);
			case (kind)
				0: begin
					l = 0; r = COORD_MAX; t = 0; b = COORD_MAX;
				end
				1: begin
					l = $urandom_range(0, COORD_MAX); r = l;
					t = $urandom_range(0, COORD_MAX); b = t;
				end
				2: begin
					if ($urandom_range(0, 1)) begin
						l = $urandom_range(1, COORD_MAX); r = $urandom_range(0, l - 1);
						t = 0; b = COORD_MAX;
					end else begin
						t = $urandom_range(1, COORD_MAX); b = $urandom_range(0, t - 1);
						l = 0; r = COORD_MAX;
					end
				end
				3: begin
					l = COORD_MAX; r = COORD_MAX; t = 0; b = 0;
				end
				default: begin
					a0 = $urandom_range(0, COORD_MAX); a1 = $urandom_range(0, COORD_MAX);
					l = (a0 < a1) ? a0 : a1; r = (a0 < a1) ? a1 : a0;
					a0 = $urandom_range(0, COORD_MAX); a1 = $urandom_range(0, COORD_MAX);
					t = (a0 < a1) ? a0 : a1; b = (a0 < a1) ? a1 : a0;
				end
			endcase
			set_window(l, r, t, b);
			gaps_on <= ($urandom_range(0, 3) != 0);
			n = (kind == 2) ? 30 : 130;
			for (i = 0; i < n; i++)
				push_seg(pick_coord(lswc_pkg::coord_t'(l), lswc_pkg::coord_t'(r)),
				         pick_coord(lswc_pkg::coord_t'(t), lswc_pkg::coord_t'(b)),
				         pick_coord(lswc_pkg::coord_t'(l), lswc_pkg::coord_t'(r)),
				         pick_coord(lswc_pkg::coord_t'(t), lswc_pkg::coord_t'(b)));
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && clip_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== line_segment_window_clipper_core.f =====
design/lswc_pkg.sv
design/lswc_div.sv
design/lswc_dp.sv
design/lswc_seq.sv
design/line_segment_window_clipper_core.sv
bench/line_segment_window_clipper_core_tb.sv
